// ===== rtl/vpf_pkg.sv =====
package vpf_pkg;

  // Result event codes.
  localparam logic [2:0] EV_SOF  = 3'd0;
  localparam logic [2:0] EV_BYTE = 3'd1;
  localparam logic [2:0] EV_EOF  = 3'd2;
  localparam logic [2:0] EV_IFS  = 3'd3;
  localparam logic [2:0] EV_ERR  = 3'd4;

  // Speed mode codes; idle means no frame is open.
  localparam logic [1:0] SPD_IDLE = 2'd0;
  localparam logic [1:0] SPD_1X   = 2'd1;
  localparam logic [1:0] SPD_4X   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_CSUM = 8'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Widths in quarter microseconds.
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned SCALED_W = WIDTH_W + 2;
  localparam logic [WIDTH_W-1:0]  SOF1_MIN   = 16'd656;
  localparam logic [WIDTH_W-1:0]  SOF1_MAX   = 16'd980;
  localparam logic [WIDTH_W-1:0]  SOF4_MIN   = 16'd164;
  localparam logic [WIDTH_W-1:0]  SOF4_MAX   = 16'd248;
  localparam logic [WIDTH_W-1:0]  GLITCH_MAX = 16'd8;
  localparam logic [SCALED_W-1:0] BIT_MIN    = 18'd96;
  localparam logic [SCALED_W-1:0] SHORT_MAX  = 18'd388;
  localparam logic [SCALED_W-1:0] LONG_MAX   = 18'd680;
  localparam logic [SCALED_W-1:0] EOF_MIN    = 18'd960;
  localparam logic [SCALED_W-1:0] IFS_MIN    = 18'd1120;

  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_XOR  = 8'hFF;
  localparam logic [7:0] CSUM_MIN_BYTES = 8'd5;
  localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_SOF1,
    CLS_SOF4,
    CLS_BIT,
    CLS_END,
    CLS_ERR
  } cls_kind_t;

  typedef struct packed {
    cls_kind_t kind;
    logic      bit_val;
    logic      ifs;
  } cls_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [7:0]         value;
    logic [7:0]         byte_index;
    logic [7:0]         crc_calc;
    logic               csum_present;
    logic               csum_ok;
    logic               csum_error_flag;
    logic [WIDTH_W-1:0] error_width;
  } res_t;

  // Byte-wise CRC-8, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/vpf_classify.sv =====
module vpf_classify (
  input  logic                        pulse_level,
  input  logic [vpf_pkg::WIDTH_W-1:0] pulse_width,
  input  logic [1:0]                  speed_mode,
  input  logic                        active_high,
  output vpf_pkg::cls_t               cls
);
  import vpf_pkg::*;

  logic                active;
  logic [SCALED_W-1:0] scaled;

  assign active = (pulse_level == active_high);
  // At 4x the bit and end limits shrink by four, so scale the width instead; the glitch limit uses the raw width.
  assign scaled = (speed_mode == SPD_4X) ? {pulse_width, 2'b00} : {2'b00, pulse_width};

  always_comb begin
    cls.kind    = CLS_NONE;
    cls.bit_val = 1'b0;
    cls.ifs     = 1'b0;
    if (speed_mode == SPD_IDLE) begin
      if (active && pulse_width >= SOF1_MIN && pulse_width <= SOF1_MAX) begin
        cls.kind = CLS_SOF1;
      end else if (active && pulse_width >= SOF4_MIN && pulse_width <= SOF4_MAX) begin
        cls.kind = CLS_SOF4;
      end
    end else if (scaled >= BIT_MIN && scaled <= LONG_MAX) begin
      cls.kind    = CLS_BIT;
      cls.bit_val = ((scaled <= SHORT_MAX) == active);
    end else if (scaled > EOF_MIN) begin
      cls.kind = CLS_END;
      cls.ifs  = (scaled > IFS_MIN);
    end else if (pulse_width > GLITCH_MAX) begin
      cls.kind = CLS_ERR;
    end
  end

endmodule

// ===== rtl/vpf_frame.sv =====
module vpf_frame (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  vpf_pkg::cls_t               cls,
  input  logic [vpf_pkg::WIDTH_W-1:0] pulse_width,
  input  logic                        verify_checksum,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [1:0]                  speed_mode,
  output vpf_pkg::res_t               res
);
  import vpf_pkg::*;

  logic [7:0] bit_shift, bit_shift_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] crc_running, crc_running_next;
  logic [7:0] crc_before_last, crc_before_last_next;
  logic [7:0] last_byte, last_byte_next;
  logic [1:0] speed_mode_next;
  logic       emit;
  res_t       res_next;

  logic [7:0] shifted;
  logic       present;
  logic [7:0] calc;

  assign shifted = {bit_shift[6:0], cls.bit_val};
  assign present = (byte_count >= CSUM_MIN_BYTES);
  assign calc    = (present ? crc_before_last : crc_running) ^ CRC_XOR;

  always_comb begin
    speed_mode_next      = speed_mode;
    bit_shift_next       = bit_shift;
    bit_count_next       = bit_count;
    byte_count_next      = byte_count;
    crc_running_next     = crc_running;
    crc_before_last_next = crc_before_last;
    last_byte_next       = last_byte;
    emit                 = 1'b0;
    res_next             = '0;
    case (cls.kind)
      CLS_SOF1, CLS_SOF4: begin
        speed_mode_next      = (cls.kind == CLS_SOF1) ? SPD_1X : SPD_4X;
        bit_shift_next       = '0;
        bit_count_next       = '0;
        byte_count_next      = '0;
        crc_running_next     = CRC_INIT;
        crc_before_last_next = CRC_INIT;
        last_byte_next       = '0;
        emit                 = 1'b1;
        res_next.event_kind  = EV_SOF;
        res_next.value       = (cls.kind == CLS_SOF1) ? 8'd1 : 8'd4;
      end
      CLS_BIT: begin
        bit_count_next = bit_count + 3'd1;
        if (bit_count == 3'd7) begin
          bit_shift_next       = '0;
          crc_before_last_next = crc_running;
          crc_running_next     = crc8_update(crc_running, shifted);
          last_byte_next       = shifted;
          if (byte_count != BYTE_COUNT_MAX) begin
            byte_count_next = byte_count + 8'd1;
          end
          emit                = 1'b1;
          res_next.event_kind = EV_BYTE;
          res_next.value      = shifted;
          res_next.byte_index = byte_count;
        end else begin
          bit_shift_next = shifted;
        end
      end
      CLS_END, CLS_ERR: begin
        speed_mode_next      = SPD_IDLE;
        bit_shift_next       = '0;
        bit_count_next       = '0;
        byte_count_next      = '0;
        crc_running_next     = CRC_INIT;
        crc_before_last_next = CRC_INIT;
        last_byte_next       = '0;
        emit                 = 1'b1;
        if (cls.kind == CLS_END) begin
          // Partial bits of an unfinished byte are simply dropped here.
          res_next.event_kind      = cls.ifs ? EV_IFS : EV_EOF;
          res_next.value           = present ? last_byte : 8'd0;
          res_next.byte_index      = byte_count;
          res_next.crc_calc        = calc;
          res_next.csum_present    = present;
          res_next.csum_ok         = present && (calc == last_byte);
          res_next.csum_error_flag = verify_checksum && present && (calc != last_byte);
        end else begin
          res_next.event_kind  = EV_ERR;
          res_next.error_width = pulse_width;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode      <= SPD_IDLE;
      bit_shift       <= '0;
      bit_count       <= '0;
      byte_count      <= '0;
      crc_running     <= CRC_INIT;
      crc_before_last <= CRC_INIT;
      last_byte       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        speed_mode      <= speed_mode_next;
        bit_shift       <= bit_shift_next;
        bit_count       <= bit_count_next;
        byte_count      <= byte_count_next;
        crc_running     <= crc_running_next;
        crc_before_last <= crc_before_last_next;
        last_byte       <= last_byte_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= res_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    speed_mode == SPD_IDLE |-> bit_count == 3'd0 && byte_count == 8'd0)
    else $error("frame counters not clear while idle");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && (cls.kind == CLS_END || cls.kind == CLS_ERR) |=> speed_mode == SPD_IDLE)
    else $error("frame did not close after end or error");

  a_sof_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.event_kind == EV_SOF |-> res.value == 8'd1 || res.value == 8'd4)
    else $error("start item carries a bad speed");

  a_err_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.event_kind != EV_ERR |-> res.error_width == '0)
    else $error("error width set on a non-error item");

  a_ok_needs_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.csum_ok |-> res.csum_present && !res.csum_error_flag)
    else $error("checksum flags inconsistent");

endmodule

// ===== rtl/vpw_pulse_frame_decoder.sv =====
// Channel  | Direction | Handshake              | Payload
// in       | input     | in_valid / in_ready    | pulse_level, pulse_width
// out      | output    | out_valid / out_ready  | event_kind .. error_width
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pulse per cycle is taken unless the output stalls; a pulse's result passes the input
// register, then the result register. The rate is set by the frame state update.
// Reset is synchronous: the decoder goes idle, active_high = 0, verify_checksum = 1.
// A stalled output holds its result; the input register then keeps its pulse, and
// a new pulse is taken only once the input register is empty or moving on.
module vpw_pulse_frame_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pulse_level,
  input  logic [vpf_pkg::WIDTH_W-1:0]         pulse_width,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          event_kind,
  output logic [7:0]                          value,
  output logic [7:0]                          byte_index,
  output logic [7:0]                          crc_calc,
  output logic                                csum_present,
  output logic                                csum_ok,
  output logic                                csum_error_flag,
  output logic [vpf_pkg::WIDTH_W-1:0]         error_width,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vpf_pkg::*;

  logic               active_high;
  logic               verify_checksum;
  logic               s1_valid;
  logic               s1_level;
  logic [WIDTH_W-1:0] s1_width;
  logic               advance;
  logic [1:0]         speed_mode;
  cls_t               cls;
  res_t               res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high     <= 1'b0;
      verify_checksum <= 1'b1;
      s1_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_ACTIVE_HIGH) begin
        active_high <= cfg_data[0];
      end
      if (cfg_valid && cfg_index == CFG_VERIFY_CSUM) begin
        verify_checksum <= cfg_data[0];
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= pulse_level;
      s1_width <= pulse_width;
    end
  end

  vpf_classify u_classify (
    .pulse_level (s1_level),
    .pulse_width (s1_width),
    .speed_mode  (speed_mode),
    .active_high (active_high),
    .cls         (cls)
  );

  vpf_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .cls             (cls),
    .pulse_width     (s1_width),
    .verify_checksum (verify_checksum),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .speed_mode      (speed_mode),
    .res             (res)
  );

  assign event_kind      = res.event_kind;
  assign value           = res.value;
  assign byte_index      = res.byte_index;
  assign crc_calc        = res.crc_calc;
  assign csum_present    = res.csum_present;
  assign csum_ok         = res.csum_ok;
  assign csum_error_flag = res.csum_error_flag;
  assign error_width     = res.error_width;

endmodule
